// File: src/knsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knsl_pkg: shared types and constants of the k-nearest sorted list
// Field widths, beat structs, command and register codes, cell link types.
// ----------------------------------------------------------------------------
package knsl_pkg;

    localparam int ID_W      = 20;
    localparam int COORD_W   = 16;
    localparam int DIST_W    = 34;
    localparam int CMD_W     = 2;
    localparam int RIDX_W    = 4;
    localparam int RANK_W    = 4;
    localparam int FILL_W    = 5;
    localparam int NCOUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2
    } t_knsl_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_X = 2'd0,
        REG_QUERY_Y = 2'd1,
        REG_QUERY_Z = 2'd2,
        REG_NCOUNT  = 2'd3
    } t_knsl_reg;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [ID_W-1:0]           cand_id;
        logic signed [COORD_W-1:0] cand_x;
        logic signed [COORD_W-1:0] cand_y;
        logic signed [COORD_W-1:0] cand_z;
        logic [RIDX_W-1:0]         read_index;
    } t_knsl_in;

    typedef struct packed {
        logic                accepted;
        logic [RANK_W-1:0]   rank;
        logic [DIST_W-1:0]   search_radius;
        logic [FILL_W-1:0]   fill_count;
        logic [ID_W-1:0]     entry_id;
        logic [DIST_W-1:0]   entry_dist;
    } t_knsl_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_knsl_point;

    typedef struct packed {
        logic              strict;
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id;
    } t_knsl_bcast;

    typedef struct packed {
        logic              flag;
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id;
    } t_knsl_link;

endpackage

// File: src/knsl_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knsl_dist: squared distance unit
// Registers the three axis squares, then their sum as the squared distance.
// ----------------------------------------------------------------------------
module knsl_dist (
    input  logic                            i_clk,
    input  logic                            i_sq_en,
    input  logic                            i_sum_en,
    input  knsl_pkg::t_knsl_point           i_query,
    input  knsl_pkg::t_knsl_point           i_cand,
    output logic [knsl_pkg::DIST_W-1:0]     o_dist
);
    import knsl_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;

    logic signed [DIFF_W-1:0]   w_dx, w_dy, w_dz;
    logic signed [2*DIFF_W-1:0] w_px, w_py, w_pz;
    logic [SQ_W-1:0]            r_sq_x, r_sq_y, r_sq_z;
    logic [DIST_W-1:0]          r_dist;

    assign w_dx = {i_cand.x[COORD_W-1], i_cand.x} - {i_query.x[COORD_W-1], i_query.x};
    assign w_dy = {i_cand.y[COORD_W-1], i_cand.y} - {i_query.y[COORD_W-1], i_query.y};
    assign w_dz = {i_cand.z[COORD_W-1], i_cand.z} - {i_query.z[COORD_W-1], i_query.z};
    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;
    assign w_pz = w_dz * w_dz;

    always_ff @(posedge i_clk) begin
        if (i_sq_en) begin
            r_sq_x <= w_px[SQ_W-1:0];
            r_sq_y <= w_py[SQ_W-1:0];
            r_sq_z <= w_pz[SQ_W-1:0];
        end
        if (i_sum_en) begin
            r_dist <= DIST_W'(r_sq_x) + DIST_W'(r_sq_y) + DIST_W'(r_sq_z);
        end
    end

    assign o_dist = r_dist;

endmodule

// File: src/knsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knsl_cell: one compare-and-shift cell of the sorted list
// Holds one entry, compares it with the broadcast distance and, on an
// insert, keeps its entry, takes the new one or takes its left neighbour's.
// ----------------------------------------------------------------------------
module knsl_cell (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  knsl_pkg::t_knsl_bcast           i_bc,
    input  logic                            i_active,
    input  knsl_pkg::t_knsl_link            i_left,
    output knsl_pkg::t_knsl_link            o_link,
    output logic                            o_take,
    output logic [knsl_pkg::DIST_W-1:0]     o_next_dist
);
    import knsl_pkg::*;

    logic [DIST_W-1:0] r_dist, n_dist;
    logic [ID_W-1:0]   r_id, n_id;
    logic              w_flag;

    assign w_flag = i_bc.strict ? (i_active && (r_dist < i_bc.sq_dist))
                                : (i_active && (r_dist <= i_bc.sq_dist));

    always_comb begin
        o_take = !w_flag && i_left.flag;
        if (w_flag) begin
            n_dist = r_dist;
            n_id   = r_id;
        end else if (o_take) begin
            n_dist = i_bc.sq_dist;
            n_id   = i_bc.id;
        end else begin
            n_dist = i_left.sq_dist;
            n_id   = i_left.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dist <= n_dist;
            r_id   <= n_id;
        end
    end

    assign o_link      = '{flag: w_flag, sq_dist: r_dist, id: r_id};
    assign o_next_dist = n_dist;

endmodule

// File: src/k_nearest_sorted_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_sorted_list: k nearest neighbours of one 3-D query point
// A row of compare-and-shift cells keeps the nearest candidates sorted by
// squared distance; clear, offer and read commands give one result each.
//
//   channel   direction   handshake              beat
//   in        input       i_in_valid/o_in_stall  t_knsl_in
//   out       output      o_out_valid/i_out_stall t_knsl_out
//   cfg       input       i_cfg_valid/o_cfg_ready index and data
//
// An item passes the axis squares, the distance sum and the cell update in turn.
// One item is in flight at a time, so the input takes no new beat until
// the cell update of the last one is done. The result is registered; a
// stalled result holds the cell update back and with it the next input beat.
// Reset clears the fill count, radius and handshake state; cells need none.
// ----------------------------------------------------------------------------
module k_nearest_sorted_list #(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  knsl_pkg::t_knsl_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output knsl_pkg::t_knsl_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [knsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [knsl_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import knsl_pkg::*;

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SEL_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUM  = 3'b010,
        ST_CELL = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic signed [COORD_W-1:0] r_query_x, r_query_y, r_query_z;
    logic [NCOUNT_W-1:0]      r_ncount;
    logic [CNT_W-1:0]         r_held, n_held;
    logic [DIST_W-1:0]        r_radius, n_radius;
    logic [CMD_W-1:0]         r_cmd;
    logic [ID_W-1:0]          r_id;
    logic [RIDX_W-1:0]        r_rindex;
    logic                     r_out_valid, n_out_valid;
    t_knsl_out                r_out, n_out;

    logic                     w_in_fire, w_cfg_fire, w_fire, w_ins, w_load;
    logic [DIST_W-1:0]        w_dist;
    logic [CNT_W-1:0]         w_k, w_limit;
    logic                     w_filling, w_hit;
    logic [IDX_W-1:0]         w_rank;
    logic [DIST_W-1:0]        w_last, w_rd_dist;
    logic [ID_W-1:0]          w_rd_id;
    t_knsl_bcast              w_bc;
    t_knsl_point              w_query, w_cand;
    t_knsl_link               w_link [MAX_NEIGHBORS+1];
    logic                     w_active [MAX_NEIGHBORS];
    logic                     w_take [MAX_NEIGHBORS];
    logic [DIST_W-1:0]        w_next_dist [MAX_NEIGHBORS];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_fire      = (r_state == ST_CELL) && (!r_out_valid || !i_out_stall);

    assign w_query = '{x: r_query_x, y: r_query_y, z: r_query_z};
    assign w_cand  = '{x: i_in_data.cand_x, y: i_in_data.cand_y, z: i_in_data.cand_z};

    knsl_dist u_dist (
        .i_clk    (i_clk),
        .i_sq_en  (w_in_fire),
        .i_sum_en (r_state == ST_SUM),
        .i_query  (w_query),
        .i_cand   (w_cand),
        .o_dist   (w_dist)
    );

    always_comb begin
        if (r_ncount == '0) begin
            w_k = CNT_W'(1);
        end else if (32'(r_ncount) > MAX_NEIGHBORS) begin
            w_k = CNT_W'(MAX_NEIGHBORS);
        end else begin
            w_k = CNT_W'(r_ncount);
        end
        w_filling = (r_held < w_k);
        w_limit   = w_filling ? r_held : w_k;
    end

    assign w_link[0] = '{flag: 1'b1, sq_dist: '0, id: '0};
    assign w_load    = w_fire && w_ins;
    assign w_bc      = '{strict: !w_filling, sq_dist: w_dist, id: r_id};

    for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_cell
        assign w_active[j] = (CNT_W'(j) < w_limit);
        knsl_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_bc        (w_bc),
            .i_active    (w_active[j]),
            .i_left      (w_link[j]),
            .o_link      (w_link[j+1]),
            .o_take      (w_take[j]),
            .o_next_dist (w_next_dist[j])
        );
    end

    always_comb begin
        w_hit     = 1'b0;
        w_rank    = '0;
        w_last    = '0;
        w_rd_dist = '0;
        w_rd_id   = '0;
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (w_take[j] && (CNT_W'(j) < w_k)) begin
                w_hit  = 1'b1;
                w_rank = w_rank | IDX_W'(j);
            end
            if (CNT_W'(j + 1) == w_k) begin
                w_last = w_last | w_next_dist[j];
            end
            if ((SEL_W'(r_rindex) == SEL_W'(j)) && (CNT_W'(j) < r_held)) begin
                w_rd_dist = w_rd_dist | w_link[j+1].sq_dist;
                w_rd_id   = w_rd_id | w_link[j+1].id;
            end
        end
    end

    always_comb begin
        n_held   = r_held;
        n_radius = r_radius;
        w_ins    = 1'b0;
        n_out    = '{accepted: 1'b0, rank: '0, search_radius: '0, fill_count: '0,
                     entry_id: '0, entry_dist: '0};
        case (r_cmd)
            CMD_CLEAR: begin
                n_held   = '0;
                n_radius = '0;
            end
            CMD_OFFER: begin
                if (w_filling) begin
                    w_ins    = 1'b1;
                    n_held   = r_held + CNT_W'(1);
                    n_radius = (w_dist > r_radius) ? w_dist : r_radius;
                end else if ((w_dist <= r_radius) && w_hit) begin
                    w_ins    = 1'b1;
                    n_held   = w_k;
                    n_radius = w_last;
                end
            end
            CMD_READ: begin
                n_out.entry_id   = w_rd_id;
                n_out.entry_dist = w_rd_dist;
            end
            default: begin
            end
        endcase
        n_out.accepted      = w_ins;
        n_out.rank          = w_ins ? RANK_W'(w_rank) : '0;
        n_out.search_radius = n_radius;
        n_out.fill_count    = FILL_W'(n_held);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = w_fire || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_radius    <= '0;
            r_query_x   <= '0;
            r_query_y   <= '0;
            r_query_z   <= '0;
            r_ncount    <= NCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_fire) begin
                r_held   <= n_held;
                r_radius <= n_radius;
            end
            if (w_cfg_fire) begin
                case (i_cfg_index)
                    REG_QUERY_X: r_query_x <= i_cfg_data;
                    REG_QUERY_Y: r_query_y <= i_cfg_data;
                    REG_QUERY_Z: r_query_z <= i_cfg_data;
                    REG_NCOUNT:  r_ncount  <= i_cfg_data[NCOUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd    <= i_in_data.cmd;
            r_id     <= i_in_data.cand_id;
            r_rindex <= i_in_data.read_index;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/knsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knsl_checker: port-level checks of the k-nearest sorted list
// Watches the beats at the top level's ports and flags impossible results.
// ----------------------------------------------------------------------------
module knsl_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  knsl_pkg::t_knsl_out   o_out_data
);
    import knsl_pkg::*;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input beat taken while an item was still in flight");

    a_insert_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |->
            (o_out_data.entry_id == '0) && (o_out_data.entry_dist == '0))
        else $error("accepted result carries entry data");

    a_empty_no_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.fill_count == '0) |->
            (o_out_data.search_radius == '0) && !o_out_data.accepted)
        else $error("empty list reports a radius or an insert");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed or dropped");

endmodule

bind k_nearest_sorted_list knsl_checker u_knsl_checker (.*);

// File: tb/sv/tb_k_nearest_sorted_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_nearest_sorted_list: self-checking bench for the k-nearest sorted list
// Drives clear, offer, read and unused-command beats under several query
// points and neighbour counts. A behavioural copy of the list predicts every
// result beat, and a monitor compares each beat field by field. The sender
// runs in bursts and the receiver stalls in patterns of its own.
// ----------------------------------------------------------------------------
module tb_k_nearest_sorted_list;

    import knsl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } t_stall_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_knsl_in             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_knsl_out            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // Behavioural copy of the list and its settings.
    logic signed [COORD_W-1:0] qry_x = '0;
    logic signed [COORD_W-1:0] qry_y = '0;
    logic signed [COORD_W-1:0] qry_z = '0;
    logic [NCOUNT_W-1:0]       k_setting = NCOUNT_RESET;
    logic [DIST_W-1:0]         list_dist [LIST_DEPTH];
    logic [ID_W-1:0]           list_id   [LIST_DEPTH];
    int                        list_fill = 0;
    logic [DIST_W-1:0]         list_radius = '0;

    t_knsl_out   expected_results [$];
    t_knsl_out   exp_beat;
    int          errors      = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          run_left    = 0;
    logic        run_stall   = 1'b0;

    k_nearest_sorted_list #(
        .MAX_NEIGHBORS(LIST_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [DIST_W-1:0] sq_distance(input t_knsl_in item);
        longint dx;
        longint dy;
        longint dz;
        logic [DIST_W-1:0] d;
        dx = longint'(item.cand_x) - longint'(qry_x);
        dy = longint'(item.cand_y) - longint'(qry_y);
        dz = longint'(item.cand_z) - longint'(qry_z);
        d = dx * dx + dy * dy + dz * dz;
        return d;
    endfunction

    function automatic void store_entry(input int pos, input int last,
                                        input logic [ID_W-1:0] id,
                                        input logic [DIST_W-1:0] d);
        int j;
        for (j = last; j > pos; j--) begin
            list_dist[j] = list_dist[j-1];
            list_id[j]   = list_id[j-1];
        end
        list_dist[pos] = d;
        list_id[pos]   = id;
    endfunction

    function automatic t_knsl_out knn_predict(input t_knsl_in item);
        t_knsl_out         res;
        logic [DIST_W-1:0] d;
        int                k;
        int                n;
        int                pos;
        res = '0;
        k = (k_setting == 0) ? 1 : ((k_setting > LIST_DEPTH) ? LIST_DEPTH : k_setting);
        case (item.cmd)
            CMD_CLEAR: begin
                list_fill   = 0;
                list_radius = '0;
            end
            CMD_OFFER: begin
                d   = sq_distance(item);
                n   = list_fill;
                pos = 0;
                if (n < k) begin
                    while (pos < n && list_dist[pos] <= d) pos++;
                    store_entry(pos, n, item.cand_id, d);
                    list_fill = n + 1;
                    if (d > list_radius) list_radius = d;
                    res.accepted = 1'b1;
                    res.rank     = RANK_W'(pos);
                end else if (d <= list_radius) begin
                    while (pos < k && list_dist[pos] < d) pos++;
                    if (pos < k) begin
                        store_entry(pos, k - 1, item.cand_id, d);
                        list_fill    = k;
                        list_radius  = list_dist[k-1];
                        res.accepted = 1'b1;
                        res.rank     = RANK_W'(pos);
                    end
                end
            end
            CMD_READ: begin
                if (int'(item.read_index) < list_fill) begin
                    res.entry_id   = list_id[item.read_index];
                    res.entry_dist = list_dist[item.read_index];
                end
            end
            default: begin
            end
        endcase
        res.search_radius = list_radius;
        res.fill_count    = FILL_W'(list_fill);
        return res;
    endfunction

    function automatic t_knsl_in rand_item();
        t_knsl_in item;
        item.cmd        = CMD_W'($urandom_range(0, 3));
        item.cand_id    = ID_W'($urandom);
        item.cand_x     = COORD_W'($urandom);
        item.cand_y     = COORD_W'($urandom);
        item.cand_z     = COORD_W'($urandom);
        item.read_index = RIDX_W'($urandom);
        return item;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [NCOUNT_W-1:0] pick_k();
        case ($urandom_range(0, 7))
            0: return 5'd1;
            1: return 5'd16;
            2: return 5'd0;
            3: return NCOUNT_W'($urandom_range(17, 31));
            4: return 5'd2;
            default: return NCOUNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(
            input logic signed [COORD_W-1:0] q, input int spread);
        int v;
        if (spread == 0) return COORD_W'($urandom);
        v = int'(q) + int'($urandom_range(0, 2 * spread)) - spread;
        return v[COORD_W-1:0];
    endfunction

    task automatic report_field(input string name, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    task automatic send_item(input t_knsl_in item);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(knn_predict(item));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd);
        t_knsl_in item;
        item     = rand_item();
        item.cmd = cmd;
        send_item(item);
    endtask

    task automatic offer(input logic [ID_W-1:0] id, input logic signed [COORD_W-1:0] x,
                         input logic signed [COORD_W-1:0] y,
                         input logic signed [COORD_W-1:0] z);
        t_knsl_in item;
        item         = rand_item();
        item.cmd     = CMD_OFFER;
        item.cand_id = id;
        item.cand_x  = x;
        item.cand_y  = y;
        item.cand_z  = z;
        send_item(item);
    endtask

    task automatic read_entry(input logic [RIDX_W-1:0] idx);
        t_knsl_in item;
        item            = rand_item();
        item.cmd        = CMD_READ;
        item.read_index = idx;
        send_item(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z,
                             input logic [NCOUNT_W-1:0] k);
        t_knsl_reg            reg_order [4];
        logic [CFG_DAT_W-1:0] reg_value [4];
        int                   r;
        reg_order = '{REG_QUERY_X, REG_QUERY_Y, REG_QUERY_Z, REG_NCOUNT};
        reg_value = '{x, y, z, CFG_DAT_W'(k)};
        wait_drained();
        for (r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_order[r];
            i_cfg_data  <= reg_value[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        qry_x     = x;
        qry_y     = y;
        qry_z     = z;
        k_setting = k;
    endtask

    task automatic test_empty_list();
        send_cmd(CMD_CLEAR);
        read_entry(4'd0);
        send_cmd(CMD_UNUSED);
    endtask

    task automatic test_fill_order();
        offer(20'h00000, 16'sd1, 16'sd0, 16'sd0);
        offer(20'hFFFFF, 16'sh8000, 16'sh8000, 16'sh8000);
        offer(20'h00005, 16'sd0, 16'sd1, 16'sd0);
        offer(20'h00006, 16'sd0, 16'sd0, 16'sd0);
        read_entry(4'd0);
        read_entry(4'd3);
    endtask

    task automatic test_full_list_replace();
        configure(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 5'd2);
        send_cmd(CMD_CLEAR);
        offer(20'h00011, 16'sh8000, 16'sh8000, 16'sh8000);
        offer(20'h00012, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        offer(20'h00013, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE);
        offer(20'h00014, 16'sh7FFE, 16'sh7FFF, 16'sh7FFF);
        offer(20'h00015, 16'sh7FFD, 16'sh7FFF, 16'sh7FFF);
        read_entry(4'd1);
    endtask

    task automatic test_count_range();
        configure(16'sd0, 16'sd0, 16'sd0, 5'd0);
        send_cmd(CMD_CLEAR);
        offer(20'h00021, 16'sd3, 16'sd0, 16'sd0);
        offer(20'h00022, 16'sd2, 16'sd0, 16'sd0);
    endtask

    task automatic test_count_below_fill();
        configure(16'sd0, 16'sd0, 16'sd0, 5'd31);
        send_cmd(CMD_CLEAR);
        offer(20'h00031, 16'sd2, 16'sd0, 16'sd0);
        offer(20'h00032, 16'sd3, 16'sd0, 16'sd0);
        offer(20'h00033, 16'sd4, 16'sd0, 16'sd0);
        offer(20'h00034, 16'sd5, 16'sd0, 16'sd0);
        configure(16'sd0, 16'sd0, 16'sd0, 5'd2);
        offer(20'h00035, 16'sd4, 16'sd0, 16'sd0);
        offer(20'h00036, 16'sd1, 16'sd0, 16'sd0);
        read_entry(4'd2);
    endtask

    task automatic test_random_queries(input int n_items);
        int                        target;
        int                        len;
        int                        r;
        int                        spread;
        int                        i;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] qz;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        t_knsl_in                  item;
        target = items_sent + n_items;
        while (items_sent < target) begin
            qx = pick_coord();
            qy = pick_coord();
            qz = pick_coord();
            configure(qx, qy, qz, pick_k());
            case ($urandom_range(0, 3))
                0: spread = 2;
                1: spread = 30;
                2: spread = 1500;
                default: spread = 0;
            endcase
            // Some queries keep the old list so that a lowered count meets a fuller list.
            if ($urandom_range(0, 4) != 0) send_cmd(CMD_CLEAR);
            len = $urandom_range(25, 70);
            px  = qx;
            py  = qy;
            pz  = qz;
            for (i = 0; i < len; i++) begin
                if (i == len / 2) wait_drained();
                item = rand_item();
                r    = $urandom_range(0, 99);
                if (r < 60) begin
                    px = near_coord(qx, spread);
                    py = near_coord(qy, spread);
                    pz = near_coord(qz, spread);
                    item.cmd    = CMD_OFFER;
                    item.cand_x = px;
                    item.cand_y = py;
                    item.cand_z = pz;
                end else if (r < 70) begin
                    item.cmd    = CMD_OFFER;
                    item.cand_x = px;
                    item.cand_y = py;
                    item.cand_z = pz;
                end else if (r < 88) begin
                    item.cmd = CMD_READ;
                end else if (r < 93) begin
                    item.cmd = CMD_CLEAR;
                end else if (r < 96) begin
                    item.cmd = CMD_UNUSED;
                end else begin
                    item.cmd = CMD_OFFER;
                end
                send_item(item);
            end
        end
    endtask

    // Receiver stall pattern: free, random, or runs of stall and free.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(40, 200);
        end else begin
            mode_left = mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 99) < 40);
            end
            default: begin
                if (run_left == 0) begin
                    run_stall = ~run_stall;
                    run_left  = run_stall ? $urandom_range(3, 14) : $urandom_range(1, 6);
                end
                run_left = run_left - 1;
                i_out_stall <= run_stall;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, o_out_data);
                errors++;
            end else begin
                exp_beat = expected_results.pop_front();
                report_field("accepted", exp_beat.accepted, o_out_data.accepted);
                report_field("rank", exp_beat.rank, o_out_data.rank);
                report_field("search_radius", exp_beat.search_radius,
                             o_out_data.search_radius);
                report_field("fill_count", exp_beat.fill_count, o_out_data.fill_count);
                report_field("entry_id", exp_beat.entry_id, o_out_data.entry_id);
                report_field("entry_dist", exp_beat.entry_dist, o_out_data.entry_dist);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_fill_order();
        test_full_list_replace();
        test_count_range();
        test_count_below_fill();
        test_random_queries(490);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
